FILE: sv/ksel_pkg.sv
// ----------------------------------------------------------------------------
// ksel_pkg
// Shared widths, operation and status codes, and the compare result type for
// the k-th smallest select block.
// ----------------------------------------------------------------------------
package ksel_pkg;

    localparam int DATA_W          = 32;
    localparam int OP_W            = 2;
    localparam int RANK_W          = 11;
    localparam int STATUS_W        = 2;
    localparam int DEF_STORE_DEPTH = 1024;

    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_RANK   = 2'd1;
    localparam logic [OP_W-1:0] OP_SECOND = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_SECOND = 2'd3;

    // a against b and against c, signed
    typedef struct packed {
        logic lt_b;
        logic eq_b;
        logic lt_c;
    } cmp_res_t;

endpackage

FILE: sv/ksel_if.sv
// ----------------------------------------------------------------------------
// ksel_cmd_if / ksel_rsp_if
// Valid/ready channels carrying command and response transactions.
// ----------------------------------------------------------------------------
interface ksel_cmd_if import ksel_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            operation;
    logic signed [DATA_W-1:0]   value;
    logic [RANK_W-1:0]          rank;

    modport source (output valid, operation, value, rank, input ready);
    modport sink   (input valid, operation, value, rank, output ready);
endinterface

interface ksel_rsp_if import ksel_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [DATA_W-1:0]   result_value;
    logic [STATUS_W-1:0]        status;

    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface

FILE: sv/ksel_cmp.sv
// ----------------------------------------------------------------------------
// ksel_cmp
// Shared signed compare unit: one operand against two references.
// ----------------------------------------------------------------------------
module ksel_cmp import ksel_pkg::*;
(
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    input  logic signed [DATA_W-1:0] c,
    output cmp_res_t                 res
);

    assign res.lt_b = (a < b);
    assign res.eq_b = (a == b);
    assign res.lt_c = (a < c);

endmodule

FILE: sv/ksel_store.sv
// ----------------------------------------------------------------------------
// ksel_store
// Element memory: one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
module ksel_store import ksel_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH,
    parameter int ADDR_W      = $clog2(STORE_DEPTH)
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic signed [DATA_W-1:0] wdata,
    input  logic                     re,
    input  logic [ADDR_W-1:0]        raddr_a,
    input  logic [ADDR_W-1:0]        raddr_b,
    output logic signed [DATA_W-1:0] rdata_a,
    output logic signed [DATA_W-1:0] rdata_b
);

    logic signed [DATA_W-1:0] mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: sv/kth_smallest_select_top.sv
// ----------------------------------------------------------------------------
// kth_smallest_select_top
// Load, clear, rank query (quickselect, Lomuto partition, last element as
// pivot, in place) and second-smallest-distinct query over a signed store.
// ----------------------------------------------------------------------------
// Load, clear and rejected queries: one transaction per cycle while the
//   response side is ready. Rank query: each swap in a partition takes two
//   writes, set by the single write port of the store.
// Second-smallest query: two read passes.
// Reset clears the element count and control; store contents stay undefined.
module kth_smallest_select_top import ksel_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    ksel_cmd_if.sink   cmd,
    ksel_rsp_if.source rsp
);

    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int CW    = $clog2(STORE_DEPTH + 1);
    localparam int CMP_W = (CW > RANK_W) ? CW : RANK_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PIV_RD = 4'd1;
    localparam logic [3:0] S_PIV_LD = 4'd2;
    localparam logic [3:0] S_PT_RD  = 4'd3;
    localparam logic [3:0] S_PT_CMP = 4'd4;
    localparam logic [3:0] S_PT_SW2 = 4'd5;
    localparam logic [3:0] S_FN_RD  = 4'd6;
    localparam logic [3:0] S_FN_WR1 = 4'd7;
    localparam logic [3:0] S_FN_WR2 = 4'd8;
    localparam logic [3:0] S_SCAN   = 4'd9;
    localparam logic [3:0] S_DRAIN  = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0]               state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            lo_reg, lo_next;
    logic [AW-1:0]            hi_reg, hi_next;
    logic [AW-1:0]            j_reg, j_next;
    logic [AW-1:0]            nxt_reg, nxt_next;
    logic [AW-1:0]            target_reg, target_next;
    logic [AW-1:0]            scan_idx_reg, scan_idx_next;
    logic                     pass_reg, pass_next;
    logic                     is_rank_reg, is_rank_next;
    logic                     found_reg, found_next;
    logic                     rd_pend_reg, rd_first_reg;
    logic                     rsp_valid_reg, rsp_valid_next;
    logic signed [DATA_W-1:0] pivot_reg, pivot_next;
    logic signed [DATA_W-1:0] minv_reg, minv_next;
    logic signed [DATA_W-1:0] best_reg, best_next;
    logic signed [DATA_W-1:0] res_reg, res_next;
    logic [STATUS_W-1:0]      status_reg, status_next;

    logic                     out_free;
    logic                     accept;
    logic                     we, re;
    logic [AW-1:0]            waddr, raddr_a, raddr_b;
    logic signed [DATA_W-1:0] wdata, rdata_a, rdata_b;
    logic signed [DATA_W-1:0] cmp_b;
    cmp_res_t                 cmp;
    logic [AW-1:0]            count_m1;
    logic [RANK_W-1:0]        rank_m1;
    logic                     rank_bad;
    logic                     j_at_end;

    ksel_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .ADDR_W      (AW)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .re      (re),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign cmp_b = (state_reg == S_PT_CMP) ? pivot_reg : minv_reg;

    ksel_cmp u_cmp (
        .a   (rdata_a),
        .b   (cmp_b),
        .c   (best_reg),
        .res (cmp)
    );

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = cmd.valid && cmd.ready;

    assign count_m1 = AW'(count_reg - CW'(1));
    assign rank_m1  = cmd.rank - RANK_W'(1);
    assign rank_bad = (cmd.rank == '0) || (CMP_W'(cmd.rank) > CMP_W'(count_reg));
    assign j_at_end = ((j_reg + AW'(1)) == hi_reg);

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.result_value = res_reg;
    assign rsp.status       = status_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        j_next         = j_reg;
        nxt_next       = nxt_reg;
        target_next    = target_reg;
        scan_idx_next  = scan_idx_reg;
        pass_next      = pass_reg;
        is_rank_next   = is_rank_reg;
        found_next     = found_reg;
        pivot_next     = pivot_reg;
        minv_next      = minv_reg;
        best_next      = best_reg;
        res_next       = res_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        we             = 1'b0;
        waddr          = nxt_reg;
        wdata          = rdata_a;
        re             = 1'b0;
        raddr_a        = j_reg;
        raddr_b        = nxt_reg;

        // scan data arrives in the cycle after its address
        if (rd_pend_reg)
        begin
            if (!pass_reg)
            begin
                if (rd_first_reg || cmp.lt_b)
                begin
                    minv_next = rdata_a;
                end
            end
            else if (!cmp.lt_b && !cmp.eq_b && (!found_reg || cmp.lt_c))
            begin
                best_next  = rdata_a;
                found_next = 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_valid_next = 1'b1;
                    res_next       = '0;
                    status_next    = ST_OK;
                    unique case (cmd.operation)
                        OP_LOAD:
                        begin
                            if (count_reg < CW'(STORE_DEPTH))
                            begin
                                we         = 1'b1;
                                waddr      = AW'(count_reg);
                                wdata      = cmd.value;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                        OP_RANK:
                        begin
                            if (rank_bad)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                rsp_valid_next = rsp_valid_reg && !rsp.ready;
                                is_rank_next   = 1'b1;
                                target_next    = AW'(rank_m1);
                                lo_next        = '0;
                                hi_next        = count_m1;
                                state_next     = S_PIV_RD;
                            end
                        end
                        OP_SECOND:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next    = INT_MAX;
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                rsp_valid_next = rsp_valid_reg && !rsp.ready;
                                is_rank_next   = 1'b0;
                                pass_next      = 1'b0;
                                found_next     = 1'b0;
                                scan_idx_next  = '0;
                                state_next     = S_SCAN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_PIV_RD:
            begin
                re         = 1'b1;
                raddr_a    = hi_reg;
                state_next = S_PIV_LD;
            end
            S_PIV_LD:
            begin
                pivot_next = rdata_a;
                j_next     = lo_reg;
                nxt_next   = lo_reg;
                state_next = (lo_reg == hi_reg) ? S_FN_RD : S_PT_RD;
            end
            S_PT_RD:
            begin
                re         = 1'b1;
                state_next = S_PT_CMP;
            end
            S_PT_CMP:
            begin
                if (cmp.lt_b || cmp.eq_b)
                begin
                    // first half of the swap: element j goes to the boundary
                    we         = 1'b1;
                    state_next = S_PT_SW2;
                end
                else if (j_at_end)
                begin
                    state_next = S_FN_RD;
                end
                else
                begin
                    j_next     = j_reg + AW'(1);
                    state_next = S_PT_RD;
                end
            end
            S_PT_SW2:
            begin
                we       = 1'b1;
                waddr    = j_reg;
                wdata    = rdata_b;
                nxt_next = nxt_reg + AW'(1);
                if (j_at_end)
                begin
                    state_next = S_FN_RD;
                end
                else
                begin
                    j_next     = j_reg + AW'(1);
                    state_next = S_PT_RD;
                end
            end
            S_FN_RD:
            begin
                re         = 1'b1;
                state_next = S_FN_WR1;
            end
            S_FN_WR1:
            begin
                we         = 1'b1;
                waddr      = hi_reg;
                wdata      = rdata_b;
                state_next = S_FN_WR2;
            end
            S_FN_WR2:
            begin
                we    = 1'b1;
                wdata = pivot_reg;
                if (nxt_reg == target_reg)
                begin
                    state_next = S_DONE;
                end
                else if (target_reg < nxt_reg)
                begin
                    hi_next    = nxt_reg - AW'(1);
                    state_next = S_PIV_RD;
                end
                else
                begin
                    lo_next    = nxt_reg + AW'(1);
                    state_next = S_PIV_RD;
                end
            end
            S_SCAN:
            begin
                re      = 1'b1;
                raddr_a = scan_idx_reg;
                if (scan_idx_reg == count_m1)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + AW'(1);
                end
            end
            S_DRAIN:
            begin
                if (!pass_reg)
                begin
                    pass_next     = 1'b1;
                    scan_idx_next = '0;
                    state_next    = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    if (is_rank_reg)
                    begin
                        res_next    = pivot_reg;
                        status_next = ST_OK;
                    end
                    else
                    begin
                        res_next    = found_reg ? best_reg : INT_MAX;
                        status_next = found_reg ? ST_OK : ST_NO_SECOND;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            rd_first_reg  <= 1'b0;
            pass_reg      <= 1'b0;
            is_rank_reg   <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            rd_pend_reg   <= (state_reg == S_SCAN);
            rd_first_reg  <= (scan_idx_reg == '0);
            pass_reg      <= pass_next;
            is_rank_reg   <= is_rank_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        j_reg        <= j_next;
        nxt_reg      <= nxt_next;
        target_reg   <= target_next;
        scan_idx_reg <= scan_idx_next;
        pivot_reg    <= pivot_next;
        minv_reg     <= minv_next;
        best_reg     <= best_next;
        res_reg      <= res_next;
        status_reg   <= status_next;
    end

endmodule
